### hw/rtl/bndm_pkg.sv
// ----------------------------------------------------------------------------
// bndm_pkg
// Shared types and constants of the BNDM pattern search block.
// ----------------------------------------------------------------------------
package bndm_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_PATTERN_DEF  = 32;
    localparam int ALPHABET_DEF     = 256;
    localparam int WINDOW_DEPTH_DEF = 64;

    // The pattern registers hold 32 bytes in all.
    localparam int PAT_BYTES = 32;
    localparam int PB_IW     = 5;

    // Configuration port.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;
    localparam int LEN_RW = 6;

    localparam logic [CFG_IW-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PATTERN_B0_7   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PATTERN_B8_15  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PATTERN_B16_23 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PATTERN_B24_31 = 3'd4;

    // Input operation codes.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef logic [PAT_BYTES-1:0][7:0] t_pat_bytes;

    // Scan-side read request into the mask table.
    typedef struct packed {
        logic       en;
        logic [7:0] sym;
    } t_mask_rd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FIN,
        S_EMIT
    } t_state;

endpackage

### hw/rtl/bndm_ram.sv
// ----------------------------------------------------------------------------
// bndm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bndm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bndm_mask_table.sv
// ----------------------------------------------------------------------------
// bndm_mask_table
// Per-symbol bit-mask table. Rebuilds itself from the pattern with one
// read-modify-write per in-alphabet pattern byte; valid bits stand in for clearing.
// ----------------------------------------------------------------------------
module bndm_mask_table import bndm_pkg::*; #(
    parameter int MASK_W   = 32,
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int LEN_W    = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rebuild,
    input  logic [LEN_W-1:0]  i_len_used,
    input  t_pat_bytes        i_pattern,
    input  t_mask_rd          i_rd,
    output logic              o_busy,
    output logic [MASK_W-1:0] o_mask
);

    localparam int SW = $clog2(ALPHABET);

    logic                r_busy;
    logic                r_phase;
    logic [LEN_W-1:0]    r_k;
    logic [ALPHABET-1:0] r_valid;
    logic                r_rd_valid;
    logic [SW-1:0]       r_sym;
    logic [MASK_W-1:0]   r_bit;

    logic [PB_IW:0]      w_k_ext;
    logic [7:0]          w_pbyte;
    logic                w_in_alpha;
    logic                w_build_rd;
    logic                w_re;
    logic [SW-1:0]       w_raddr;
    logic                w_we;
    logic [MASK_W-1:0]   w_ram_q;
    logic [MASK_W-1:0]   w_masked;

    assign w_k_ext    = (PB_IW + 1)'(r_k);
    assign w_pbyte    = i_pattern[w_k_ext[PB_IW-1:0]];
    assign w_in_alpha = ({1'b0, w_pbyte} < 9'(ALPHABET));
    assign w_build_rd = r_busy && !r_phase && (r_k != i_len_used) && w_in_alpha;
    assign w_re       = w_build_rd || i_rd.en;
    assign w_raddr    = r_busy ? w_pbyte[SW-1:0] : i_rd.sym[SW-1:0];
    assign w_we       = r_busy && r_phase;

    // An entry that has not been written since the last rebuild reads as zero.
    assign w_masked = r_rd_valid ? w_ram_q : '0;

    bndm_ram #(
        .WIDTH (MASK_W),
        .DEPTH (ALPHABET)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_sym),
        .i_wdata (w_masked | r_bit),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_phase    <= 1'b0;
            r_k        <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else if (i_rebuild) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_k     <= '0;
            r_valid <= '0;
        end else begin
            if (w_re) begin
                r_rd_valid <= r_valid[w_raddr];
            end
            if (r_busy) begin
                if (!r_phase) begin
                    if (r_k == i_len_used) begin
                        r_busy <= 1'b0;
                    end else if (w_in_alpha) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_k <= r_k + LEN_W'(1);
                    end
                end else begin
                    r_valid[r_sym] <= 1'b1;
                    r_phase        <= 1'b0;
                    r_k            <= r_k + LEN_W'(1);
                end
            end
        end
    end

    // Byte k of the pattern sets bit (length - 1 - k) of its symbol's mask.
    always_ff @(posedge i_clk) begin
        if (w_build_rd) begin
            r_sym <= w_pbyte[SW-1:0];
            r_bit <= MASK_W'(1) << (i_len_used - LEN_W'(1) - r_k);
        end
    end

    assign o_busy = r_busy;
    assign o_mask = w_masked;

endmodule

### hw/rtl/bndm_pattern_search.sv
// ----------------------------------------------------------------------------
// bndm_pattern_search
// Counts exact occurrences of a configured pattern in a byte stream with the
// backward nondeterministic DAWG matching rule.
//
//   Channel   Direction  Handshake                   Payload
//   in        in         i_in_valid / o_in_ready     i_op, i_text_byte
//   out       out        o_out_valid / i_out_ready   o_match_found, o_match_start,
//                                                    o_is_total, o_total_count
//   cfg       in         i_cfg_we                    i_cfg_index, i_cfg_wdata
//
// A text byte that completes no window passes through S_CHECK back to S_IDLE.
// A byte that completes a window of length m goes on through S_SCAN and S_FIN,
// and through S_EMIT when it gives a result; the backward scan reads one byte a
// cycle through the window RAM and the mask RAM read ports. An end-of-text beat
// goes through S_EMIT. The mask table is rebuilt after reset and after every
// write to a defined register; o_in_ready stays low meanwhile.
// A result waits in the output register; the next beat is taken meanwhile and
// only a further result stalls on it.
// ----------------------------------------------------------------------------
module bndm_pattern_search import bndm_pkg::*; #(
    parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
    parameter int ALPHABET     = ALPHABET_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [7:0]        i_text_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_match_found,
    output logic [31:0]       o_match_start,
    output logic              o_is_total,
    output logic [31:0]       o_total_count,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int L_MP  = (MAX_PATTERN < WINDOW_DEPTH) ? MAX_PATTERN : WINDOW_DEPTH;
    localparam int L_MAX = (L_MP < PAT_BYTES) ? L_MP : PAT_BYTES;
    localparam int LW    = $clog2(L_MAX + 1);
    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_DEPTH - 1);

    // Configuration.
    logic [LEN_RW-1:0] r_len;
    logic [CFG_DW-1:0] r_pat [4];
    logic              r_rebuild_req;
    logic [LW-1:0]     w_len_used;
    t_pat_bytes        w_pattern;

    // Control and text state.
    t_state         r_state, n_state;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic [31:0]    r_br, n_br;
    logic [31:0]    r_ws, n_ws;
    logic [31:0]    r_total, n_total;

    // Scan.
    logic [PW-1:0]    r_rd_idx, n_rd_idx;
    logic [LW-1:0]    r_issue, n_issue;
    logic [LW-1:0]    r_i, n_i;
    logic [LW-1:0]    r_last, n_last;
    logic [L_MAX-1:0] r_d, n_d;
    logic             r_hit, n_hit;
    logic             r_p1, n_p1;
    logic             r_p2, n_p2;
    logic             r_oob;

    // Pending and delivered result.
    logic        r_pend_found, n_pend_found;
    logic [31:0] r_pend_start, n_pend_start;
    logic        r_pend_total, n_pend_total;
    logic [31:0] r_pend_count, n_pend_count;
    logic        r_out_vld, n_out_vld;
    logic        r_out_found;
    logic [31:0] r_out_start;
    logic        r_out_total;
    logic [31:0] r_out_count;

    logic             w_in_acc;
    logic             w_win_we;
    logic             w_issue;
    logic [7:0]       w_win_q;
    logic             w_mask_busy;
    logic [L_MAX-1:0] w_mask;
    t_mask_rd         w_mask_rd;
    logic [31:0]      w_pending;
    logic             w_go;
    logic [L_MAX-1:0] w_d_and;
    logic [LW-1:0]    w_i_next;
    logic             w_term;
    logic [31:0]      w_total_inc;
    logic             w_slot_free;

    assign w_len_used = (r_len > LEN_RW'(L_MAX)) ? LW'(L_MAX) : LW'(r_len);
    assign w_pattern  = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    assign o_in_ready  = (r_state == S_IDLE) && !w_mask_busy && !r_rebuild_req;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_win_we    = w_in_acc && (i_op == OP_TEXT);
    assign w_slot_free = !r_out_vld || i_out_ready;

    assign w_pending   = r_br - r_ws;
    assign w_go        = (w_len_used != '0) && !w_pending[31]
                         && (w_pending >= 32'(w_len_used));

    assign w_d_and     = r_d & (r_oob ? '0 : w_mask);
    assign w_i_next    = r_i - LW'(1);
    assign w_term      = (r_state == S_SCAN) && r_p2
                         && ((w_d_and == '0) || (w_i_next == '0));
    assign w_issue     = (r_state == S_SCAN) && (r_issue != '0) && !w_term;
    assign w_total_inc = (r_total == '1) ? r_total : r_total + 32'd1;

    assign w_mask_rd.en  = r_p1 && (r_state == S_SCAN);
    assign w_mask_rd.sym = w_win_q;

    bndm_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (w_win_we),
        .i_waddr (r_ptr),
        .i_wdata (i_text_byte),
        .i_re    (w_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (w_win_q)
    );

    bndm_mask_table #(
        .MASK_W   (L_MAX),
        .ALPHABET (ALPHABET),
        .LEN_W    (LW)
    ) u_mask_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rebuild  (r_rebuild_req),
        .i_len_used (w_len_used),
        .i_pattern  (w_pattern),
        .i_rd       (w_mask_rd),
        .o_busy     (w_mask_busy),
        .o_mask     (w_mask)
    );

    // Configuration registers; any valid write restarts the mask rebuild.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= LEN_RW'(1);
            r_pat[0]      <= '0;
            r_pat[1]      <= '0;
            r_pat[2]      <= '0;
            r_pat[3]      <= '0;
            r_rebuild_req <= 1'b0;
        end else begin
            r_rebuild_req <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LENGTH: begin
                        r_len         <= i_cfg_wdata[LEN_RW-1:0];
                        r_rebuild_req <= 1'b1;
                    end
                    REG_PATTERN_B0_7: begin
                        r_pat[0]      <= i_cfg_wdata;
                        r_rebuild_req <= 1'b1;
                    end
                    REG_PATTERN_B8_15: begin
                        r_pat[1]      <= i_cfg_wdata;
                        r_rebuild_req <= 1'b1;
                    end
                    REG_PATTERN_B16_23: begin
                        r_pat[2]      <= i_cfg_wdata;
                        r_rebuild_req <= 1'b1;
                    end
                    REG_PATTERN_B24_31: begin
                        r_pat[3]      <= i_cfg_wdata;
                        r_rebuild_req <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_op == OP_END) ? S_EMIT : S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_go ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (w_term) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = r_hit ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath updates for each state.
    always_comb begin
        n_ptr        = r_ptr;
        n_br         = r_br;
        n_ws         = r_ws;
        n_total      = r_total;
        n_rd_idx     = r_rd_idx;
        n_issue      = r_issue;
        n_i          = r_i;
        n_last       = r_last;
        n_d          = r_d;
        n_hit        = r_hit;
        n_p1         = 1'b0;
        n_p2         = 1'b0;
        n_pend_found = r_pend_found;
        n_pend_start = r_pend_start;
        n_pend_total = r_pend_total;
        n_pend_count = r_pend_count;
        n_out_vld    = i_out_ready ? 1'b0 : r_out_vld;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == OP_END) begin
                        n_pend_found = 1'b0;
                        n_pend_start = '0;
                        n_pend_total = 1'b1;
                        n_pend_count = r_total;
                        n_total      = '0;
                        n_br         = '0;
                        n_ws         = '0;
                    end else begin
                        n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + PW'(1);
                        n_br  = r_br + 32'd1;
                    end
                end
            end
            S_CHECK: begin
                // With more bytes pending than the length, jump to the newest window.
                if (w_go && (w_pending != 32'(w_len_used))) begin
                    n_ws = r_br - 32'(w_len_used);
                end
                n_rd_idx = (r_ptr == '0) ? PTR_LAST : r_ptr - PW'(1);
                n_issue  = w_len_used;
                n_i      = w_len_used;
                n_last   = w_len_used;
                n_d      = '1;
                n_hit    = 1'b0;
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_rd_idx = (r_rd_idx == '0) ? PTR_LAST : r_rd_idx - PW'(1);
                    n_issue  = r_issue - LW'(1);
                end
                n_p1 = w_issue;
                n_p2 = r_p1 && !w_term;
                if (r_p2) begin
                    n_i = w_i_next;
                    n_d = w_d_and << 1;
                    if (w_d_and != '0) begin
                        if (w_i_next != '0) begin
                            n_last = w_i_next;
                        end else begin
                            n_hit = 1'b1;
                        end
                    end
                end
            end
            S_FIN: begin
                n_ws = r_ws + 32'(r_last);
                if (r_hit) begin
                    n_total      = w_total_inc;
                    n_pend_found = 1'b1;
                    n_pend_start = r_ws;
                    n_pend_total = 1'b0;
                    n_pend_count = w_total_inc;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_vld = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_br      <= '0;
            r_ws      <= '0;
            r_total   <= '0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_br      <= n_br;
            r_ws      <= n_ws;
            r_total   <= n_total;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_issue      <= n_issue;
        r_i          <= n_i;
        r_last       <= n_last;
        r_d          <= n_d;
        r_oob        <= ({1'b0, w_win_q} >= 9'(ALPHABET));
        r_pend_found <= n_pend_found;
        r_pend_start <= n_pend_start;
        r_pend_total <= n_pend_total;
        r_pend_count <= n_pend_count;
        if ((r_state == S_EMIT) && w_slot_free) begin
            r_out_found <= r_pend_found;
            r_out_start <= r_pend_start;
            r_out_total <= r_pend_total;
            r_out_count <= r_pend_count;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_match_found = r_out_found;
    assign o_match_start = r_out_start;
    assign o_is_total    = r_out_total;
    assign o_total_count = r_out_count;

`ifndef SYNTHESIS
    a_scan_table_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !w_mask_busy)
        else $error("mask table rebuild overlaps a window scan");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_match_found, o_is_total}))
        else $error("result beat is neither a match nor a total, or both");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output register loaded outside the emit state");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_i != '0) && (r_i <= w_len_used)))
        else $error("scan index left the window");
`endif

endmodule
